// ----- sv/sm3_hash_engine_unit_macros.svh -----
// ---------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Shared property forms for the port checker; clock aclk, reset aresetn.
// ---------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_UNIT_MACROS_SVH
`define SM3_HASH_ENGINE_UNIT_MACROS_SVH

// hold cons in the cycle after ante
`define SM3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// hold cons in the same cycle as ante
`define SM3_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/sm3_pkg.sv -----
// ---------------------------------------------------------------------------
// SM3 package
// Command and status types between controller and datapath, SM3 constants
// and the permutation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

    typedef struct packed {
        logic wr_byte;
        logic pad;
        logic pad_len;
        logic clr_len;
        logic load;
        logic round;
        logic emit;
    } sm3_cmd_t;

    typedef struct packed {
        logic blk_full;
        logic pos_gt55;
        logic round_last;
        logic out_busy;
    } sm3_sts_t;

    typedef logic [31:0] word_t;

    localparam word_t T0 = 32'h79CC4519;
    localparam word_t T1 = 32'h7A879D8A;
    localparam word_t T1_R16 = {T1[15:0], T1[31:16]};

    localparam word_t IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [5:0] LEN_POS_MAX = 6'd55;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

`default_nettype wire

// ----- sv/sm3_ctrl.sv -----
// ---------------------------------------------------------------------------
// SM3 controller
// Sequences byte intake, padding, block compression and digest hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_byte_valid,
    input  wire logic             s_last,
    output logic                  s_ready,
    input  wire sm3_pkg::sm3_sts_t sts,
    output sm3_pkg::sm3_cmd_t     cmd
);
    import sm3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    state_t after_reg, after_next;
    logic   take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_ready && s_valid;

    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    cmd.wr_byte = s_byte_valid;
                    if (s_byte_valid && sts.blk_full) begin
                        state_next = ST_LOAD;
                        after_next = s_last ? ST_PAD : ST_IDLE;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.pad     = 1'b1;
                cmd.pad_len = !sts.pos_gt55;
                state_next  = ST_LOAD;
                after_next  = sts.pos_gt55 ? ST_LEN : ST_OUT;
            end
            ST_LEN: begin
                cmd.clr_len = 1'b1;
                state_next  = ST_LOAD;
                after_next  = ST_OUT;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (sts.round_last) begin
                    state_next = after_reg;
                end
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sm3_datapath.sv -----
// ---------------------------------------------------------------------------
// SM3 datapath
// Block buffer, byte count, message schedule window, round unit, chaining
// value and the digest output buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sm3_pkg::sm3_cmd_t cmd,
    input  wire logic [7:0]        s_byte,
    output sm3_pkg::sm3_sts_t      sts,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic [31:0]            m_word,
    output logic [2:0]             m_index,
    output logic                   m_last
);
    import sm3_pkg::*;

    word_t       blk_reg   [16];
    word_t       w_reg     [16];
    word_t       v_reg     [8];
    word_t       v_next    [8];
    word_t       chain_reg [8];
    word_t       out_reg   [8];
    word_t       pad_word  [16];
    word_t       t_reg;
    logic [28:0] cnt_reg;
    logic [5:0]  rnd_reg;
    logic [3:0]  out_cnt_reg;
    logic [2:0]  idx_reg;
    logic [5:0]  pos;
    logic [4:0]  sh;
    word_t       len_bits;
    word_t       a12, ss1, ss2, ff, gg, tt1, tt2, nw;
    logic        early;
    logic        m_hs;

    assign pos      = cnt_reg[5:0];
    assign sh       = {~cnt_reg[1:0], 3'b000};
    assign len_bits = {cnt_reg, 3'b000};
    assign early    = (rnd_reg[5:4] == 2'b00);
    assign m_hs     = m_valid && m_ready;

    assign sts.blk_full   = (pos == 6'd63);
    assign sts.pos_gt55   = (pos > LEN_POS_MAX);
    assign sts.round_last = (rnd_reg == 6'd63);
    assign sts.out_busy   = (out_cnt_reg != 4'd0);

    assign m_valid = (out_cnt_reg != 4'd0);
    assign m_word  = out_reg[0];
    assign m_index = idx_reg;
    assign m_last  = (out_cnt_reg == 4'd1);

    always_comb begin
        for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
                if (6'(w * 4 + b) < pos) begin
                    pad_word[w][31 - 8 * b -: 8] = blk_reg[w][31 - 8 * b -: 8];
                end else if (6'(w * 4 + b) == pos) begin
                    pad_word[w][31 - 8 * b -: 8] = 8'h80;
                end else begin
                    pad_word[w][31 - 8 * b -: 8] = 8'h00;
                end
            end
        end
    end

    always_comb begin
        a12 = rotl(v_reg[0], 12);
        ss1 = rotl(a12 + v_reg[4] + t_reg, 7);
        ss2 = ss1 ^ a12;
        if (early) begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end else begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + w_reg[0];
        v_next[0] = tt1;
        v_next[1] = v_reg[0];
        v_next[2] = rotl(v_reg[1], 9);
        v_next[3] = v_reg[2];
        v_next[4] = perm0(tt2);
        v_next[5] = v_reg[4];
        v_next[6] = rotl(v_reg[5], 19);
        v_next[7] = v_reg[6];
        nw = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 15))
             ^ rotl(w_reg[3], 7) ^ w_reg[10];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            blk_reg[cnt_reg[5:2]][sh +: 8] <= s_byte;
        end else if (cmd.pad) begin
            for (int w = 0; w < 14; w++) begin
                blk_reg[w] <= pad_word[w];
            end
            if (cmd.pad_len) begin
                blk_reg[14] <= '0;
                blk_reg[15] <= len_bits;
            end else begin
                blk_reg[14] <= pad_word[14];
                blk_reg[15] <= pad_word[15];
            end
        end else if (cmd.clr_len) begin
            for (int w = 0; w < 15; w++) begin
                blk_reg[w] <= '0;
            end
            blk_reg[15] <= len_bits;
        end

        if (cmd.load) begin
            w_reg <= blk_reg;
            v_reg <= chain_reg;
            t_reg <= T0;
        end else if (cmd.round) begin
            for (int k = 0; k < 15; k++) begin
                w_reg[k] <= w_reg[k + 1];
            end
            w_reg[15] <= nw;
            v_reg     <= v_next;
            t_reg     <= (rnd_reg == 6'd15) ? T1_R16 : rotl(t_reg, 1);
        end

        if (cmd.emit) begin
            out_reg <= chain_reg;
        end else if (m_hs) begin
            for (int k = 0; k < 7; k++) begin
                out_reg[k] <= out_reg[k + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg   <= IV;
            cnt_reg     <= '0;
            rnd_reg     <= '0;
            out_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            if (cmd.wr_byte) begin
                cnt_reg <= cnt_reg + 29'd1;
            end else if (cmd.emit) begin
                cnt_reg <= '0;
            end

            if (cmd.load) begin
                rnd_reg <= '0;
            end else if (cmd.round) begin
                rnd_reg <= rnd_reg + 6'd1;
            end

            if (cmd.round && sts.round_last) begin
                for (int k = 0; k < 8; k++) begin
                    chain_reg[k] <= chain_reg[k] ^ v_next[k];
                end
            end else if (cmd.emit) begin
                chain_reg <= IV;
            end

            if (cmd.emit) begin
                out_cnt_reg <= 4'd8;
                idx_reg     <= '0;
            end else if (m_hs) begin
                out_cnt_reg <= out_cnt_reg - 4'd1;
                idx_reg     <= idx_reg + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/sm3_hash_engine_unit.sv -----
// Throughput: one byte request per cycle; a byte that completes a block
// holds tready low through the load and 64 rounds, one round per cycle.
// Last request: a pad step, one or two compressions, a length-block step
// between them when padding spills over, a hand-off step once the
// previous digest has drained, then 8 digest words, one per cycle of tready.
// Reset: synchronous; chaining value returns to the IV, count to zero.
// ---------------------------------------------------------------------------
// SM3 hash engine top level
// Byte stream in, eight big-endian digest words out per message.
// ---------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast
);
    import sm3_pkg::*;

    sm3_cmd_t cmd;
    sm3_sts_t sts;

    sm3_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_byte_valid (s_axis_tuser),
        .s_last       (s_axis_tlast),
        .s_ready      (s_axis_tready),
        .sts          (sts),
        .cmd          (cmd)
    );

    sm3_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_byte  (s_axis_tdata),
        .sts     (sts),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_word  (m_axis_tdata),
        .m_index (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- sv/sm3_checker.sv -----
// ---------------------------------------------------------------------------
// SM3 port checker
// Watches the top level ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sm3_hash_engine_unit_macros.svh"

module sm3_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    logic       s_hs;
    logic       m_hs;
    logic       s_fin;
    logic       m_fin;
    logic       m_more;
    logic       m_stall;
    logic [2:0] nx_idx;

    assign s_hs    = s_axis_tvalid && s_axis_tready;
    assign m_hs    = m_axis_tvalid && m_axis_tready;
    assign s_fin   = s_hs && s_axis_tlast;
    assign m_fin   = m_axis_tvalid && m_axis_tlast;
    assign m_more  = m_hs && !m_axis_tlast;
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign nx_idx  = m_axis_tuser + 3'd1;

    `SM3_ASSERT_NEXT(a_m_hold, m_stall, m_axis_tvalid, "m valid dropped")
    `SM3_ASSERT_NEXT(a_m_stable, m_stall, $stable(m_axis_tdata), "m data moved")
    `SM3_ASSERT_NEXT(a_idx_step, m_more, m_axis_tvalid && m_axis_tuser == $past(nx_idx), "idx skip")
    `SM3_ASSERT_SAME(a_last_idx, m_fin, m_axis_tuser == 3'd7, "last word not index 7")
    `SM3_ASSERT_NEXT(a_busy_last, s_fin, !s_axis_tready, "request taken during finish")

endmodule

bind sm3_hash_engine_unit sm3_checker u_sm3_checker (.*);

`default_nettype wire

// ----- verif/sm3_hash_engine_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SM3 hash engine unit test
// Streams byte messages of many lengths into the engine: empty messages, short
// ones, lengths around the padding and block boundaries, and random lengths up
// to a few blocks. Ignored requests are mixed in, and the message end comes
// with or without a data byte. A built-in SM3 predictor computes each digest,
// and the monitor checks every digest word, index and last flag. Both
// channels pause at random, and the receiver holds off long enough for the
// input side to stall.
// ---------------------------------------------------------------------------

module sm3_hash_engine_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 450;
    localparam int TAIL_WAIT   = 200;

    localparam logic [31:0] ROUND_K_LOW  = 32'h79CC4519;
    localparam logic [31:0] ROUND_K_HIGH = 32'h7A879D8A;
    localparam logic [31:0] START_VEC [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       ends_msg;
    } byte_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] msg_byte
    logic        s_axis_tuser = 1'b0;    // [0] byte_valid
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_index
    logic        m_axis_tlast;

    byte_req_t    byte_queue [$];
    digest_word_t digest_expect [$];
    byte_req_t    offered;
    digest_word_t want;

    logic [31:0] chain_q [8];
    logic [31:0] blk_q [16];
    logic [28:0] len_q;

    int mismatch_count = 0;
    int msgs_done = 0;
    int bytes_done = 0;
    int words_checked = 0;
    int cycle_count = 0;
    int tx_pause = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;
    int long_holds_left = 2;
    int items_queued = 0;
    int msg_len = 0;

    sm3_hash_engine_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
        int unsigned s;
        s = n % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] mix_p0(logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] mix_p1(logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    function automatic void sm3_restart();
        int k;
        for (k = 0; k < 8; k++)
            chain_q[k] = START_VEC[k];
        for (k = 0; k < 16; k++)
            blk_q[k] = 32'h0;
        len_q = '0;
    endfunction

    function automatic void put_byte(int pos, logic [7:0] b);
        blk_q[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endfunction

    function automatic void sm3_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] a12, ss1, ss2, ff, gg, t1, t2, tj, wj, wj4, nw;
        int k, j;
        for (k = 0; k < 16; k++)
            w[k] = blk_q[k];
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
        for (j = 0; j < 64; j++) begin
            wj  = w[j % 16];
            wj4 = w[(j + 4) % 16];
            tj  = (j < 16) ? ROUND_K_LOW : ROUND_K_HIGH;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            t1 = ff + d + ss2 + (wj ^ wj4);
            t2 = gg + h + ss1 + wj;
            d = c; c = rol32(b, 9); b = a; a = t1;
            h = g; g = rol32(f, 19); f = e; e = mix_p0(t2);
            nw = mix_p1(wj ^ w[(j + 7) % 16] ^ rol32(w[(j + 13) % 16], 15))
                 ^ rol32(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
            w[j % 16] = nw;
        end
        chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
        chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
    endfunction

    function automatic void sm3_absorb(byte_req_t r);
        int pos, k;
        digest_word_t dw;
        if (r.has_data) begin
            put_byte(int'(len_q[5:0]), r.data);
            len_q = len_q + 1'b1;
            bytes_done++;
            if (len_q[5:0] == 6'd0)
                sm3_compress();
        end
        if (!r.ends_msg)
            return;
        pos = int'(len_q[5:0]);
        put_byte(pos, PAD_MARK);
        for (k = pos + 1; k < 64; k++)
            put_byte(k, 8'h00);
        if (pos > 55) begin
            sm3_compress();
            for (k = 0; k < 16; k++)
                blk_q[k] = 32'h0;
        end
        blk_q[14] = 32'h0;
        blk_q[15] = {len_q, 3'b000};
        sm3_compress();
        for (k = 0; k < 8; k++) begin
            dw.word = chain_q[k];
            dw.idx  = 3'(k);
            dw.fin  = (k == 7);
            digest_expect.push_back(dw);
        end
        msgs_done++;
        sm3_restart();
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_req(logic [7:0] data, logic has_data, logic ends_msg);
        byte_req_t r;
        r.data = data;
        r.has_data = has_data;
        r.ends_msg = ends_msg;
        byte_queue.push_back(r);
        items_queued++;
    endfunction

    function automatic void queue_message(int len, bit noisy);
        bit fin_on_data;
        int i;
        fin_on_data = (len > 0) && $urandom_range(0, 1);
        for (i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_req(8'($urandom), 1'b0, 1'b0);
            push_req(8'($urandom), 1'b1, fin_on_data && (i == len - 1));
        end
        if (!fin_on_data)
            push_req(8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic int pick_length();
        int r;
        int edges [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 8);
        if (r < 65)
            return edges[$urandom_range(0, 9)];
        return $urandom_range(0, 130);
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_pause = 0;
            tx_calm = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                sm3_absorb(offered);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_calm == 0 && $urandom_range(0, 63) == 0)
                    tx_calm = $urandom_range(30, 120);
                if (tx_pause > 0) begin
                    tx_pause--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    offered = byte_queue.pop_front();
                    s_axis_tdata  <= offered.data;
                    s_axis_tuser  <= offered.has_data;
                    s_axis_tlast  <= offered.ends_msg;
                    s_axis_tvalid <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm--;
                        tx_pause = 0;
                    end else begin
                        tx_pause = $urandom_range(0, 1) ? 0 : pick_pause();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // hold off the result side; the first digest meets two long holds in a row
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
            rx_calm = 0;
            long_holds_left = 2;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (long_holds_left > 0 && m_axis_tvalid) begin
            long_holds_left--;
            rx_hold = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_calm > 0) begin
            rx_calm--;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 63) == 0) begin
            rx_calm = $urandom_range(30, 120);
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_hold = pick_pause() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (digest_expect.size() == 0) begin
                flag_mismatch($sformatf("digest word %08h with nothing expected",
                                        m_axis_tdata));
            end else begin
                want = digest_expect.pop_front();
                words_checked++;
                if (m_axis_tdata !== want.word)
                    flag_mismatch($sformatf("word %0d: got %08h, want %08h",
                                            want.idx, m_axis_tdata, want.word));
                if (m_axis_tuser !== want.idx)
                    flag_mismatch($sformatf("index: got %0d, want %0d",
                                            m_axis_tuser, want.idx));
                if (m_axis_tlast !== want.fin)
                    flag_mismatch($sformatf("word %0d: last got %0b, want %0b",
                                            want.idx, m_axis_tlast, want.fin));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[sm3_hash_engine_unit] ERROR");
            $finish;
        end
    end

    initial begin
        sm3_restart();

        push_req(8'h00, 1'b0, 1'b1);
        push_req(8'h61, 1'b1, 1'b0);
        push_req(8'h62, 1'b1, 1'b0);
        push_req(8'h63, 1'b1, 1'b1);
        push_req(8'hFF, 1'b1, 1'b1);
        push_req(8'hA5, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b0);
        push_req(8'h5A, 1'b0, 1'b0);
        push_req(8'hFF, 1'b0, 1'b1);
        push_req(8'h80, 1'b1, 1'b0);
        push_req(8'h7F, 1'b1, 1'b0);
        push_req(8'h01, 1'b0, 1'b1);

        queue_message(55, 1'b0);
        queue_message(56, 1'b1);
        queue_message(63, 1'b0);
        queue_message(64, 1'b1);
        queue_message(119, 1'b1);
        while (items_queued < ITEM_TARGET) begin
            msg_len = pick_length();
            if (msg_len > ITEM_TARGET - items_queued)
                msg_len = ITEM_TARGET - items_queued;
            queue_message(msg_len, 1'b1);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_queue.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (digest_expect.size() != 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("hashed %0d messages, %0d data bytes in all", msgs_done, bytes_done);
        $display("checked %0d digest words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[sm3_hash_engine_unit] OK");
        else
            $display("[sm3_hash_engine_unit] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sm3_pkg.sv
sv/sm3_ctrl.sv
sv/sm3_datapath.sv
sv/sm3_hash_engine_unit.sv
sv/sm3_checker.sv
verif/sm3_hash_engine_unit_test.sv
